>>> rtl/pds_pkg.sv
// shared constants, widths and status codes for the pll divider search
package pds_pkg;

  // frequency limits in khz
  localparam int unsigned PFD_MIN_KHZ = 10000;
  localparam int unsigned PFD_MAX_KHZ = 133000;
  localparam int unsigned VCO_MIN_KHZ = 533000;
  localparam int unsigned VCO_MAX_KHZ = 1066000;
  localparam int unsigned OUT_MIN_KHZ = 16000;
  localparam int unsigned OUT_MAX_KHZ = 275000;

  // divider ranges
  localparam int unsigned RDIV_MAX        = 15;
  localparam int unsigned FDIV_MAX_SIMPLE = 127;
  localparam int unsigned FDIV_MAX_OTHER  = 63;
  localparam int unsigned QDIV_MIN        = 1;
  localparam int unsigned QDIV_MAX        = 6;

  // field widths
  localparam int unsigned REF_W  = 18;
  localparam int unsigned TGT_W  = 19;
  localparam int unsigned RDIV_W = 4;
  localparam int unsigned FDIV_W = 7;
  localparam int unsigned QDIV_W = 3;
  localparam int unsigned ACH_W  = 20;

  // internal widths
  localparam int unsigned RD_W   = 5;   // reference divide ratio 1..16
  localparam int unsigned NUM_W  = 25;  // ref * (f + 1)
  localparam int unsigned ACC_W  = 25;  // limit * ratio accumulators
  localparam int unsigned TRD_W  = 23;  // target * ratio
  localparam int unsigned VCO_W  = 31;  // num shifted by output exponent
  localparam int unsigned ERR_W  = 30;  // absolute error numerator
  localparam int unsigned DEN_W  = 11;  // error denominator
  localparam int unsigned PROD_W = ERR_W + DEN_W;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_REF_RANGE = 2'd1,
    ST_TGT_RANGE = 2'd2,
    ST_NONE      = 2'd3
  } status_e;

endpackage

>>> rtl/pds_ifs.sv
// valid/ready channel interfaces for request, result and configuration beats
interface pds_in_if import pds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REF_W-1:0]  ref_freq_khz;
  logic [TGT_W-1:0]  target_freq_khz;

  modport source (output valid, output ref_freq_khz, output target_freq_khz, input ready);
  modport sink   (input valid, input ref_freq_khz, input target_freq_khz, output ready);
endinterface

interface pds_out_if import pds_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [RDIV_W-1:0] ref_div;
  logic [FDIV_W-1:0] fb_div;
  logic [QDIV_W-1:0] out_div;
  logic [ACH_W-1:0]  achieved_khz;

  modport source (output valid, output status, output ref_div, output fb_div,
                  output out_div, output achieved_khz, input ready);
  modport sink   (input valid, input status, input ref_div, input fb_div,
                  input out_div, input achieved_khz, output ready);
endinterface

interface pds_cfg_if ();
  logic valid;
  logic ready;
  logic simple_path;

  modport source (output valid, output simple_path, input ready);
  modport sink   (input valid, input simple_path, output ready);
endinterface

>>> rtl/pds_mul.sv
// shared registered multiplier for the error cross products
module pds_mul import pds_pkg::*; (
  input  logic              clk_i,
  input  logic [ERR_W-1:0]  a_i,
  input  logic [DEN_W-1:0]  b_i,
  output logic [PROD_W-1:0] prod_o
);

  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

>>> rtl/pds_div.sv
// restoring divider, one quotient bit per cycle, for the achieved frequency
module pds_div import pds_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [RD_W-1:0]  divisor_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [RD_W-1:0]  rem_q;
  logic [NUM_W-1:0] dvd_q;
  logic [NUM_W-1:0] quo_q;
  logic [RD_W-1:0]  dvs_q;
  logic [RD_W:0]    rem_sh;
  logic [RD_W:0]    rem_sub;
  logic             fits;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[NUM_W-1]};
    fits    = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? rem_sub[RD_W-1:0] : rem_sh[RD_W-1:0];
      dvd_q <= {dvd_q[NUM_W-2:0], 1'b0};
      quo_q <= {quo_q[NUM_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> rtl/pll_divider_search.sv
// top level: pll divider search sequencer around a shared multiplier and divider
//
//   channel  modport  beat carries
//   -------  -------  --------------------------------------------------------
//   cfg_i    sink     simple_path (1 = simple path, resets to 1)
//   in_i     sink     ref_freq_khz, target_freq_khz
//   out_o    source   status, ref_div, fb_div, out_div, achieved_khz
//
// one request at a time; in_i.ready is high only while the sequencer is idle
// per request: accept, then skipped divider positions are stepped past in the check
//   state and each candidate in range takes check, two passes through the shared 30x11
//   multiplier and compare; the best is then run through the bit-serial divider before
//   the result beat; out-of-range requests go straight to the result beat
// the result holds on out_o until taken; cfg_i is always ready
// reset puts the sequencer idle and simple_path at 1; no clearing pass
module pll_divider_search import pds_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  pds_cfg_if.sink    cfg_i,
  pds_in_if.sink     in_i,
  pds_out_if.source  out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL_A,
    S_MUL_B,
    S_CMP,
    S_DIV_GO,
    S_DIV_WAIT,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    ADV_NONE,
    ADV_Q,
    ADV_F,
    ADV_R
  } adv_e;

  state_e             state_q;
  logic               simple_q;

  // request operands
  logic [REF_W-1:0]   ref_q;
  logic [TGT_W-1:0]   tgt_q;

  // loop position
  logic [RDIV_W-1:0]  r_q;
  logic [FDIV_W-1:0]  f_q;
  logic [QDIV_W-1:0]  q_q;

  // running products so no multiply sits in the loop control
  logic [ACC_W-1:0]   pfd_lo_q, pfd_hi_q, vco_lo_q, vco_hi_q;
  logic [TRD_W-1:0]   trd_q;
  logic [NUM_W-1:0]   num_q;

  // current candidate error err_q / den_q
  logic [ERR_W-1:0]   err_q;
  logic [DEN_W-1:0]   den_q;
  logic [PROD_W-1:0]  prod_a_q;

  // best so far
  logic               found_q;
  logic [ERR_W-1:0]   best_num_q;
  logic [DEN_W-1:0]   best_den_q;
  logic [RDIV_W-1:0]  best_r_q;
  logic [FDIV_W-1:0]  best_f_q;
  logic [QDIV_W-1:0]  best_q_q;
  logic [NUM_W-1:0]   best_vnum_q;
  logic [RD_W-1:0]    best_rd_q;

  // result
  status_e            status_q;
  logic [ACH_W-1:0]   achieved_q;

  // combinational
  logic [ACC_W-1:0]   ref_a;
  logic [RD_W-1:0]    rd;
  logic               pfd_ok, vco_s_ok, vco_n_ok;
  logic [VCO_W-1:0]   vco_n;
  logic [ERR_W-1:0]   td_w, td, num_e, err_d;
  logic [DEN_W-1:0]   den_d;
  logic [FDIV_W-1:0]  fmax;
  adv_e               adv;
  logic               q_wrap, f_step, f_wrap, r_step, last;
  logic               take;
  logic               ref_bad, tgt_bad;
  logic [ERR_W-1:0]   mul_a;
  logic [DEN_W-1:0]   mul_b;
  logic [PROD_W-1:0]  mul_p;
  logic               div_start, div_done;
  logic [NUM_W-1:0]   div_quo;
  logic               in_fire;

  assign in_fire = in_i.valid && in_i.ready;

  // request range checks, reference first
  assign ref_bad = (in_i.ref_freq_khz < REF_W'(PFD_MIN_KHZ)) ||
                   (in_i.ref_freq_khz > REF_W'(PFD_MAX_KHZ));
  assign tgt_bad = (in_i.target_freq_khz < TGT_W'(OUT_MIN_KHZ)) ||
                   (in_i.target_freq_khz > TGT_W'(OUT_MAX_KHZ));

  // candidate evaluation
  always_comb begin
    ref_a    = ACC_W'(ref_q);
    rd       = RD_W'(r_q) + RD_W'(1);
    pfd_ok   = (ref_a >= pfd_lo_q) && (ref_a <= pfd_hi_q);
    vco_s_ok = (num_q >= vco_lo_q) && (num_q <= vco_hi_q);
    vco_n    = VCO_W'(num_q) << q_q;
    vco_n_ok = (vco_n >= VCO_W'(vco_lo_q)) && (vco_n <= VCO_W'(vco_hi_q));
    // simple: den = rd << q, non-simple: den = rd
    td_w     = ERR_W'(trd_q);
    td       = simple_q ? (td_w << q_q) : td_w;
    num_e    = ERR_W'(num_q);
    err_d    = (num_e > td) ? (num_e - td) : (td - num_e);
    den_d    = simple_q ? (DEN_W'(rd) << q_q) : DEN_W'(rd);
    fmax     = simple_q ? FDIV_W'(FDIV_MAX_SIMPLE) : FDIV_W'(FDIV_MAX_OTHER);
  end

  // which loop level steps this cycle
  always_comb begin
    adv = ADV_NONE;
    case (state_q)
      S_CHECK: begin
        if (!pfd_ok) begin
          adv = ADV_R;
        end else if (simple_q && !vco_s_ok) begin
          adv = ADV_F;
        end else if (!simple_q && !vco_n_ok) begin
          adv = ADV_Q;
        end
      end
      S_CMP:   adv = ADV_Q;
      default: adv = ADV_NONE;
    endcase
    q_wrap = (adv == ADV_Q) && (q_q == QDIV_W'(QDIV_MAX));
    f_step = (adv == ADV_F) || q_wrap;
    f_wrap = f_step && (f_q == fmax);
    r_step = (adv == ADV_R) || f_wrap;
    last   = r_step && (r_q == RDIV_W'(RDIV_MAX));
  end

  // first candidate always taken, later ones only when strictly better:
  // err * best_den < best_num * den
  assign take = !found_q || (prod_a_q < mul_p);

  // shared multiplier: err * best_den first, then best_num * den
  assign mul_a = (state_q == S_MUL_A) ? err_q      : best_num_q;
  assign mul_b = (state_q == S_MUL_A) ? best_den_q : den_q;

  pds_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_p)
  );

  assign div_start = (state_q == S_DIV_GO);

  pds_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (best_vnum_q),
    .divisor_i  (best_rd_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // sequencer, control and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      simple_q <= 1'b1;
      found_q  <= 1'b0;
      r_q      <= '0;
      f_q      <= '0;
      q_q      <= '0;
      best_r_q <= '0;
      best_f_q <= '0;
      best_q_q <= '0;
      status_q <= ST_OK;
    end else begin
      if (cfg_i.valid) begin
        simple_q <= cfg_i.simple_path;
      end

      // loop stepping
      if (adv != ADV_NONE) begin
        q_q   <= ((adv == ADV_Q) && !q_wrap) ? (q_q + QDIV_W'(1)) : QDIV_W'(QDIV_MIN);
        f_q   <= r_step ? '0 : (f_step ? (f_q + FDIV_W'(1)) : f_q);
        num_q <= r_step ? NUM_W'(ref_q) : (f_step ? (num_q + NUM_W'(ref_q)) : num_q);
        if (r_step) begin
          r_q      <= r_q + RDIV_W'(1);
          pfd_lo_q <= pfd_lo_q + ACC_W'(PFD_MIN_KHZ);
          pfd_hi_q <= pfd_hi_q + ACC_W'(PFD_MAX_KHZ);
          vco_lo_q <= vco_lo_q + ACC_W'(VCO_MIN_KHZ);
          vco_hi_q <= vco_hi_q + ACC_W'(VCO_MAX_KHZ);
          trd_q    <= trd_q + TRD_W'(tgt_q);
        end
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            ref_q      <= in_i.ref_freq_khz;
            tgt_q      <= in_i.target_freq_khz;
            found_q    <= 1'b0;
            best_r_q   <= '0;
            best_f_q   <= '0;
            best_q_q   <= '0;
            achieved_q <= '0;
            r_q        <= '0;
            f_q        <= '0;
            q_q        <= QDIV_W'(QDIV_MIN);
            num_q      <= NUM_W'(in_i.ref_freq_khz);
            trd_q      <= TRD_W'(in_i.target_freq_khz);
            pfd_lo_q   <= ACC_W'(PFD_MIN_KHZ);
            pfd_hi_q   <= ACC_W'(PFD_MAX_KHZ);
            vco_lo_q   <= ACC_W'(VCO_MIN_KHZ);
            vco_hi_q   <= ACC_W'(VCO_MAX_KHZ);
            if (ref_bad) begin
              status_q <= ST_REF_RANGE;
              state_q  <= S_OUT;
            end else if (tgt_bad) begin
              status_q <= ST_TGT_RANGE;
              state_q  <= S_OUT;
            end else begin
              status_q <= ST_OK;
              state_q  <= S_CHECK;
            end
          end
        end

        S_CHECK: begin
          if (adv == ADV_NONE) begin
            err_q   <= err_d;
            den_q   <= den_d;
            state_q <= S_MUL_A;
          end else if (last) begin
            if (found_q) begin
              state_q <= S_DIV_GO;
            end else begin
              status_q <= ST_NONE;
              state_q  <= S_OUT;
            end
          end
        end

        S_MUL_A: state_q <= S_MUL_B;

        S_MUL_B: begin
          prod_a_q <= mul_p;
          state_q  <= S_CMP;
        end

        S_CMP: begin
          if (take) begin
            found_q     <= 1'b1;
            best_num_q  <= err_q;
            best_den_q  <= den_q;
            best_r_q    <= r_q;
            best_f_q    <= f_q;
            best_q_q    <= q_q;
            // floor(floor(num / 2^q) / rd) == floor(num / (rd << q))
            best_vnum_q <= simple_q ? (num_q >> q_q) : num_q;
            best_rd_q   <= rd;
          end
          if (last) begin
            state_q <= S_DIV_GO;
          end else begin
            state_q <= S_CHECK;
          end
        end

        S_DIV_GO: state_q <= S_DIV_WAIT;

        S_DIV_WAIT: begin
          if (div_done) begin
            achieved_q <= div_quo[ACH_W-1:0];
            status_q   <= ST_OK;
            state_q    <= S_OUT;
          end
        end

        S_OUT: begin
          if (out_o.ready) begin
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cfg_i.ready        = 1'b1;
  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = (state_q == S_OUT);
  assign out_o.status       = status_q;
  assign out_o.ref_div      = best_r_q;
  assign out_o.fb_div       = best_f_q;
  assign out_o.out_div      = best_q_q;
  assign out_o.achieved_khz = achieved_q;

endmodule

>>> verif/tb_top.sv
// self-checking testbench for the pll divider search block
module tb_top import pds_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // one result beat as the block presents it
  typedef struct packed {
    status_e             status;
    logic [RDIV_W-1:0]   ref_div;
    logic [FDIV_W-1:0]   fb_div;
    logic [QDIV_W-1:0]   out_div;
    logic [ACH_W-1:0]    achieved_khz;
  } pll_setting_t;

  // holds the divider settings still owed by the block, oldest first
  class divider_scoreboard;
    bit           simple_fb = 1'b1;
    pll_setting_t due[$];
    int unsigned  fail_count;
    int unsigned  checked;
    int unsigned  locked;

    // exhaustive search over r, f, q in loop order, keeping the first best fit
    function automatic pll_setting_t best_dividers(logic [REF_W-1:0] src_khz,
                                                   logic [TGT_W-1:0] tgt_khz);
      longint unsigned src, tgt, rd, num, den, td, err, fmax;
      longint unsigned best_num, best_den;
      int unsigned     br, bf, bq;
      bit              found, ok;
      pll_setting_t    res;
      src = src_khz;
      tgt = tgt_khz;
      res = '0;
      res.status = ST_OK;
      if (src < PFD_MIN_KHZ || src > PFD_MAX_KHZ) begin
        res.status = ST_REF_RANGE;
        return res;
      end
      if (tgt < OUT_MIN_KHZ || tgt > OUT_MAX_KHZ) begin
        res.status = ST_TGT_RANGE;
        return res;
      end
      fmax = simple_fb ? FDIV_MAX_SIMPLE : FDIV_MAX_OTHER;
      found = 0;
      best_num = 0;
      best_den = 0;
      br = 0;
      bf = 0;
      bq = 0;
      for (int unsigned r = 0; r <= RDIV_MAX; r++) begin
        rd = r + 1;
        // phase detector window
        if (src < PFD_MIN_KHZ * rd || src > PFD_MAX_KHZ * rd) continue;
        for (int unsigned f = 0; f <= fmax; f++) begin
          num = src * (f + 1);
          for (int unsigned q = QDIV_MIN; q <= QDIV_MAX; q++) begin
            // simple path: vco is num/rd, output divided by 2^q
            // other path: vco is num*2^q/rd, output is num/rd
            if (simple_fb) begin
              ok  = !(num < VCO_MIN_KHZ * rd || num > VCO_MAX_KHZ * rd);
              den = rd << q;
            end else begin
              ok  = !((num << q) < VCO_MIN_KHZ * rd || (num << q) > VCO_MAX_KHZ * rd);
              den = rd;
            end
            if (!ok) continue;
            td  = tgt * den;
            err = (num > td) ? num - td : td - num;
            // strict less-than keeps the earlier candidate on a tie
            if (!found || err * best_den < best_num * den) begin
              best_num = err & ((64'd1 << ERR_W) - 1);
              best_den = den & ((64'd1 << DEN_W) - 1);
              br = r;
              bf = f;
              bq = q;
              found = 1;
            end
          end
        end
      end
      if (!found) begin
        res.status = ST_NONE;
        return res;
      end
      num = src * (bf + 1);
      den = simple_fb ? ((br + 1) << bq) : (br + 1);
      res.ref_div      = RDIV_W'(br);
      res.fb_div       = FDIV_W'(bf);
      res.out_div      = QDIV_W'(bq);
      res.achieved_khz = ACH_W'(num / den);
      return res;
    endfunction

    function void note_request(logic [REF_W-1:0] src_khz, logic [TGT_W-1:0] tgt_khz);
      due.push_back(best_dividers(src_khz, tgt_khz));
    endfunction

    function void check_result(pll_setting_t got);
      pll_setting_t want;
      if (due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result beat: status %0d rdiv %0d fdiv %0d odiv %0d khz %0d",
                   got.status, got.ref_div, got.fb_div, got.out_div, got.achieved_khz);
        return;
      end
      want = due.pop_front();
      checked++;
      if (want.status == ST_OK) locked++;
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10)
          $display({"mismatch: want status %0d rdiv %0d fdiv %0d odiv %0d khz %0d, ",
                    "got status %0d rdiv %0d fdiv %0d odiv %0d khz %0d"},
                   want.status, want.ref_div, want.fb_div, want.out_div, want.achieved_khz,
                   got.status, got.ref_div, got.fb_div, got.out_div, got.achieved_khz);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   idle_off;  // when set, neither side inserts gaps

  pds_cfg_if cfg_bus ();
  pds_in_if  in_bus ();
  pds_out_if out_bus ();

  divider_scoreboard sb = new;

  pll_divider_search dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // directed requests: field extremes, each rejection, the range corners
  // and a target that many divider sets hit exactly (tie breaking)
  localparam int DIR_N = 13;
  logic [REF_W-1:0] dir_ref [DIR_N] = '{
    0, 9999, 133001, 262143, 10000, 10000, 10000,
    133000, 10000, 10000, 133000, 133000, 12000
  };
  logic [TGT_W-1:0] dir_tgt [DIR_N] = '{
    100000, 100000, 100000, 524287, 0, 15999, 275001,
    524287, 16000, 275000, 16000, 275000, 48000
  };

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // all three channels are observed at the rising edge; the scoreboard
  // tracks the feedback mode from the config beats it sees
  always @(posedge clk_i) begin
    if (rst_ni && cfg_bus.valid && cfg_bus.ready)
      sb.simple_fb = cfg_bus.simple_path;
    if (rst_ni && in_bus.valid && in_bus.ready)
      sb.note_request(in_bus.ref_freq_khz, in_bus.target_freq_khz);
    if (rst_ni && out_bus.valid && out_bus.ready)
      sb.check_result('{status_e'(out_bus.status), out_bus.ref_div, out_bus.fb_div,
                        out_bus.out_div, out_bus.achieved_khz});
  end

  // result side: random stall ahead of every beat
  initial begin
    int unsigned stall;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = idle_off ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_bus.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_bus.ready = 1'b1;
      do @(posedge clk_i); while (!out_bus.valid);
    end
  end

  // one request beat; valid stays up afterwards so a zero gap runs back to back
  task automatic send_request(input logic [REF_W-1:0] src_khz,
                              input logic [TGT_W-1:0] tgt_khz);
    int unsigned gap;
    gap = idle_off ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid           = 1'b1;
    in_bus.ref_freq_khz    = src_khz;
    in_bus.target_freq_khz = tgt_khz;
    do @(posedge clk_i); while (!in_bus.ready);
    @(negedge clk_i);
  endtask

  // stop sending and let every owed result come back
  task automatic drain_results();
    in_bus.valid = 1'b0;
    while (sb.due.size() != 0) @(negedge clk_i);
  endtask

  // only called with the block idle
  task automatic write_feedback_mode(input logic mode);
    cfg_bus.valid       = 1'b1;
    cfg_bus.simple_path = mode;
    do @(posedge clk_i); while (!cfg_bus.ready);
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  initial begin
    logic [REF_W-1:0] src_khz;
    logic [TGT_W-1:0] tgt_khz;
    logic             mode;
    rst_ni                 = 1'b0;
    idle_off               = 1'b0;
    in_bus.valid           = 1'b0;
    in_bus.ref_freq_khz    = '0;
    in_bus.target_freq_khz = '0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.simple_path    = 1'b1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed list once per feedback path
    for (int p = 0; p < 2; p++) begin
      write_feedback_mode(p == 0);
      for (int i = 0; i < DIR_N; i++) send_request(dir_ref[i], dir_tgt[i]);
      drain_results();
    end

    // random phases: both paths forced first, then random; phase 2 runs gap-free
    for (int p = 0; p < 4; p++) begin
      mode     = (p == 0) ? 1'b1 : (p == 1) ? 1'b0 : 1'($urandom_range(0, 1));
      idle_off = (p == 2);
      write_feedback_mode(mode);
      for (int i = 0; i < 25; i++) begin
        src_khz = REF_W'($urandom_range(PFD_MIN_KHZ, PFD_MAX_KHZ));
        tgt_khz = TGT_W'($urandom_range(OUT_MIN_KHZ, OUT_MAX_KHZ));
        case ($urandom_range(0, 9))
          0: begin
            // noise over the full field range
            src_khz = REF_W'($urandom_range(0, (1 << REF_W) - 1));
            tgt_khz = TGT_W'($urandom_range(0, (1 << TGT_W) - 1));
          end
          1: tgt_khz = TGT_W'($urandom_range(0, (1 << TGT_W) - 1));
          2, 3: begin
            // simple ratios of the reference, often hit exactly by several sets
            tgt_khz = TGT_W'((longint'(src_khz) * $urandom_range(1, 20))
                             / $urandom_range(1, 8));
          end
          default: ;
        endcase
        // now and then hold off until the block has caught up
        if ($urandom_range(0, 15) == 0) drain_results();
        send_request(src_khz, tgt_khz);
      end
      drain_results();
    end
    idle_off = 1'b0;

    // catch any stray beat after the last expected one
    repeat (40) @(posedge clk_i);
    $display("%0d requests checked over both feedback paths, %0d locked and %0d rejected",
             sb.checked, sb.locked, sb.checked - sb.locked);
    if (sb.fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures", sb.fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // worst case about 126 requests at 2 ns per cycle, about 13 ms in all;
  // allow several times that
  initial begin
    #60_000_000;
    $display("timeout with %0d results outstanding", sb.due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
